FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Each macro clocks on clk_i; the first also disables during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the local sequence aligner.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned MaxLenDef  = 32;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned CellMax    = 1023;
  localparam int unsigned ColW       = 18;

  localparam logic [1:0] CmdLoadRef = 2'd0;
  localparam logic [1:0] CmdLoadQry = 2'd1;
  localparam logic [1:0] CmdRun     = 2'd2;

  localparam logic [1:0] CfgMatch    = 2'd0;
  localparam logic [1:0] CfgMismatch = 2'd1;
  localparam logic [1:0] CfgGap      = 2'd2;

  typedef struct packed {
    logic [3:0] match;
    logic [4:0] mismatch;
    logic [4:0] gap;
  } cfg_t;

  typedef struct packed {
    logic load_ref;
    logic load_qry;
    logic fill_init;
    logic fill_rd;
    logic fill_cmp;
    logic tb_init;
    logic tb_up;
    logic tb_left;
    logic tb_diag;
    logic tb_eval;
    logic em_init;
    logic em_rd;
    logic em_ld;
    logic em_solo;
    logic em_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_empty;
    logic fill_last;
    logic best_zero;
    logic tb_more;
    logic solo_needed;
    logic em_last;
  } dp_status_t;

endpackage

FILE: rtl/lsa_ram.sv
// ----------------------------------------------------------------------------
// lsa_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lsa_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 32,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lsa_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsa_cfg_regs
// APB-style register file holding the three scoring values.
// ----------------------------------------------------------------------------
module lsa_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lsa_pkg::cfg_t cfg_o
);
  import lsa_pkg::*;

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match    <= 4'd3;
      cfg_q.mismatch <= 5'b11101;
      cfg_q.gap      <= 5'b11110;
    end else if (wr) begin
      case (paddr[3:2])
        CfgMatch:    cfg_q.match    <= pwdata[3:0];
        CfgMismatch: cfg_q.mismatch <= pwdata[4:0];
        CfgGap:      cfg_q.gap      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CfgMatch:    prdata = {28'd0, cfg_q.match};
      CfgMismatch: prdata = {27'd0, cfg_q.mismatch};
      CfgGap:      prdata = {27'd0, cfg_q.gap};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// Sequencer for loads, matrix fill, traceback and result emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lsa_pkg::dp_status_t status_i,
  output lsa_pkg::ctrl_cmd_t  cmd_o
);
  import lsa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FINIT = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FCMP  = 4'd3;
  localparam logic [3:0] S_TINIT = 4'd4;
  localparam logic [3:0] S_TUP   = 4'd5;
  localparam logic [3:0] S_TLEFT = 4'd6;
  localparam logic [3:0] S_TDIAG = 4'd7;
  localparam logic [3:0] S_TEVAL = 4'd8;
  localparam logic [3:0] S_EINIT = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_ELD   = 4'd11;
  localparam logic [3:0] S_ESOLO = 4'd12;
  localparam logic [3:0] S_EWAIT = 4'd13;

  logic [3:0] state_q, state_d;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EWAIT);
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            CmdLoadRef: cmd_o.load_ref = 1'b1;
            CmdLoadQry: cmd_o.load_qry = 1'b1;
            CmdRun:     state_d = S_FINIT;
            default: ;
          endcase
        end
      end
      S_FINIT: begin
        cmd_o.fill_init = 1'b1;
        state_d = S_FRD;
        if (status_i.fill_empty) state_d = S_TINIT;
      end
      S_FRD: begin
        cmd_o.fill_rd = 1'b1;
        state_d = S_FCMP;
      end
      S_FCMP: begin
        cmd_o.fill_cmp = 1'b1;
        state_d = status_i.fill_last ? S_TINIT : S_FRD;
      end
      S_TINIT: begin
        cmd_o.tb_init = 1'b1;
        state_d = status_i.best_zero ? S_EINIT : S_TUP;
      end
      S_TUP: begin
        cmd_o.tb_up = 1'b1;
        state_d = S_TLEFT;
      end
      S_TLEFT: begin
        cmd_o.tb_left = 1'b1;
        state_d = S_TDIAG;
      end
      S_TDIAG: begin
        cmd_o.tb_diag = 1'b1;
        state_d = S_TEVAL;
      end
      S_TEVAL: begin
        cmd_o.tb_eval = 1'b1;
        state_d = status_i.tb_more ? S_TUP : S_EINIT;
      end
      S_EINIT: begin
        cmd_o.em_init = 1'b1;
        state_d = status_i.solo_needed ? S_ESOLO : S_ERD;
      end
      S_ERD: begin
        cmd_o.em_rd = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        cmd_o.em_ld = 1'b1;
        state_d = S_EWAIT;
      end
      S_ESOLO: begin
        cmd_o.em_solo = 1'b1;
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_ready_i) begin
          cmd_o.em_pop = 1'b1;
          state_d = status_i.em_last ? S_IDLE : S_ERD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `LSA_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input and output both open")
  `LSA_ASSERT(a_fcmp_after_frd, (state_q == S_FCMP) |-> ($past(state_q) == S_FRD), "bad fill order")
  `LSA_ASSERT(a_wait_entry, ((state_q == S_EWAIT) && ($past(state_q) != S_EWAIT)) |-> (($past(state_q) == S_ELD) || ($past(state_q) == S_ESOLO)), "result not loaded")

endmodule

FILE: rtl/lsa_datapath.sv
// ----------------------------------------------------------------------------
// lsa_datapath
// Symbol stores, score matrix, column buffer and result registers.
// ----------------------------------------------------------------------------
module lsa_datapath #(
  parameter int unsigned MAX_LEN = lsa_pkg::MaxLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsa_pkg::cfg_t       cfg_i,
  input  lsa_pkg::ctrl_cmd_t  cmd_i,
  output lsa_pkg::dp_status_t status_o,
  input  logic [7:0]          symbol_i,
  output logic [7:0]          query_char_o,
  output logic                query_is_gap_o,
  output logic [7:0]          ref_char_o,
  output logic                ref_is_gap_o,
  output logic                last_column_o,
  output logic                none_found_o,
  output logic [4:0]          query_start_o,
  output logic [4:0]          query_end_o,
  output logic [4:0]          ref_start_o,
  output logic [4:0]          ref_end_o,
  output logic [9:0]          best_score_o
);
  import lsa_pkg::*;

  localparam int unsigned Dim = MAX_LEN + 1;
  localparam int unsigned IW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned MAW = $clog2(Dim * Dim);
  localparam int unsigned CAW = $clog2(2 * MAX_LEN);
  localparam int unsigned LW  = $clog2(2 * MAX_LEN + 1);

  logic [IW-1:0] ref_cnt_q, qry_cnt_q, i_q, j_q, bi_q, bj_q, x_q, y_q, qs_q, rs_q;
  logic [9:0]    left_q, diag_q, best_q, cur_q, up_q, lft_q;
  logic [LW-1:0] len_q, k_q, n_q;
  logic          tb_act;
  logic [7:0]    qry_rd, ref_rd;
  logic [9:0]    m_rd;
  logic [IW-1:0] row, col;
  logic [MAW-1:0] mraddr, mwaddr;
  logic [ColW-1:0] col_rd, col_wd;
  logic signed [11:0] mis_s, gap_s, pair_s, diag_s, indel_s, vs;
  logic [9:0]    up_f, mx_f, v_f, dg_t, m_t;
  logic          up_ok, left_ok, diag_ok, found;
  logic [IW-1:0] nx, ny;

  assign tb_act = cmd_i.tb_up || cmd_i.tb_left || cmd_i.tb_diag || cmd_i.tb_eval;

  lsa_ram #(.W(8), .D(MAX_LEN)) u_ref_ram (
    .clk_i, .we_i(cmd_i.load_ref && (int'(ref_cnt_q) < MAX_LEN)),
    .waddr_i(SAW'(ref_cnt_q)), .wdata_i(symbol_i),
    .raddr_i(SAW'(tb_act ? y_q - 1'b1 : j_q - 1'b1)), .rdata_o(ref_rd)
  );

  lsa_ram #(.W(8), .D(MAX_LEN)) u_qry_ram (
    .clk_i, .we_i(cmd_i.load_qry && (int'(qry_cnt_q) < MAX_LEN)),
    .waddr_i(SAW'(qry_cnt_q)), .wdata_i(symbol_i),
    .raddr_i(SAW'(tb_act ? x_q - 1'b1 : i_q - 1'b1)), .rdata_o(qry_rd)
  );

  always_comb begin
    if (cmd_i.tb_up) begin
      row = x_q - 1'b1; col = y_q;
    end else if (cmd_i.tb_left) begin
      row = x_q; col = y_q - 1'b1;
    end else if (cmd_i.tb_diag) begin
      row = x_q - 1'b1; col = y_q - 1'b1;
    end else begin
      row = i_q - 1'b1; col = j_q;
    end
  end

  assign mraddr = MAW'(row) * MAW'(Dim) + MAW'(col);
  assign mwaddr = MAW'(i_q) * MAW'(Dim) + MAW'(j_q);

  lsa_ram #(.W(10), .D(Dim * Dim)) u_mat_ram (
    .clk_i, .we_i(cmd_i.fill_cmp), .waddr_i(mwaddr), .wdata_i(v_f),
    .raddr_i(mraddr), .rdata_o(m_rd)
  );

  lsa_ram #(.W(ColW), .D(2 * MAX_LEN)) u_col_ram (
    .clk_i, .we_i(cmd_i.tb_eval && found), .waddr_i(CAW'(len_q)), .wdata_i(col_wd),
    .raddr_i(CAW'(len_q - k_q - 1'b1)), .rdata_o(col_rd)
  );

  // Scoring arithmetic shared by fill and traceback.
  always_comb begin
    mis_s  = {{7{cfg_i.mismatch[4]}}, cfg_i.mismatch};
    gap_s  = {{7{cfg_i.gap[4]}}, cfg_i.gap};
    pair_s = (qry_rd == ref_rd) ? {8'd0, cfg_i.match} : mis_s;
    up_f   = (i_q == IW'(1)) ? 10'd0 : m_rd;
    mx_f   = (up_f > left_q) ? up_f : left_q;
    diag_s = $signed({2'b00, diag_q}) + pair_s;
    indel_s = $signed({2'b00, mx_f}) + gap_s;
    vs = 12'sd0;
    if (diag_s > vs) vs = diag_s;
    if (indel_s > vs) vs = indel_s;
    v_f = (vs > $signed(12'(CellMax))) ? 10'(CellMax) : vs[9:0];
  end

  // Traceback predecessor choice: larger score wins, insert before delete before diagonal.
  always_comb begin
    dg_t    = ((x_q == IW'(1)) || (y_q == IW'(1))) ? 10'd0 : m_rd;
    up_ok   = ($signed({2'b00, up_q}) + gap_s) == $signed({2'b00, cur_q});
    left_ok = ($signed({2'b00, lft_q}) + gap_s) == $signed({2'b00, cur_q});
    diag_ok = ($signed({2'b00, dg_t}) + pair_s) == $signed({2'b00, cur_q});
    found  = 1'b0;
    m_t    = 10'd0;
    nx     = x_q;
    ny     = y_q;
    col_wd = '0;
    if (up_ok) begin
      found = 1'b1; m_t = up_q; nx = x_q - 1'b1; ny = y_q;
      col_wd = {qry_rd, 1'b0, 8'd0, 1'b1};
    end
    if (left_ok && (!found || (lft_q > m_t))) begin
      found = 1'b1; m_t = lft_q; nx = x_q; ny = y_q - 1'b1;
      col_wd = {8'd0, 1'b1, ref_rd, 1'b0};
    end
    if (diag_ok && (!found || (dg_t > m_t))) begin
      found = 1'b1; m_t = dg_t; nx = x_q - 1'b1; ny = y_q - 1'b1;
      col_wd = {qry_rd, 1'b0, ref_rd, 1'b0};
    end
  end

  assign status_o.fill_empty  = (ref_cnt_q == '0) || (qry_cnt_q == '0);
  assign status_o.fill_last   = (i_q == qry_cnt_q) && (j_q == ref_cnt_q);
  assign status_o.best_zero   = (best_q == 10'd0);
  assign status_o.tb_more     = found && (nx != '0) && (ny != '0) && (m_t != 10'd0) &&
                                ((int'(len_q) + 1) < 2 * MAX_LEN);
  assign status_o.solo_needed = (best_q == 10'd0) || (len_q == '0);
  assign status_o.em_last     = last_column_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cnt_q <= '0;
      qry_cnt_q <= '0;
    end else begin
      if (cmd_i.load_ref && (int'(ref_cnt_q) < MAX_LEN)) ref_cnt_q <= ref_cnt_q + 1'b1;
      if (cmd_i.load_qry && (int'(qry_cnt_q) < MAX_LEN)) qry_cnt_q <= qry_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_init) begin
      i_q <= IW'(1); j_q <= IW'(1); left_q <= '0; diag_q <= '0;
      best_q <= '0; bi_q <= '0; bj_q <= '0;
    end
    if (cmd_i.fill_cmp) begin
      if (v_f > best_q) begin
        best_q <= v_f; bi_q <= i_q; bj_q <= j_q;
      end
      if (j_q == ref_cnt_q) begin
        j_q <= IW'(1); i_q <= i_q + 1'b1; left_q <= '0; diag_q <= '0;
      end else begin
        j_q <= j_q + 1'b1; left_q <= v_f; diag_q <= up_f;
      end
    end
    if (cmd_i.tb_init) begin
      x_q <= bi_q; y_q <= bj_q; cur_q <= best_q; len_q <= '0;
      qs_q <= bi_q - 1'b1; rs_q <= bj_q - 1'b1;
    end
    if (cmd_i.tb_left) up_q <= (x_q == IW'(1)) ? 10'd0 : m_rd;
    if (cmd_i.tb_diag) lft_q <= (y_q == IW'(1)) ? 10'd0 : m_rd;
    if (cmd_i.tb_eval && found) begin
      x_q <= nx; y_q <= ny; cur_q <= m_t; len_q <= len_q + 1'b1;
      if (m_t != 10'd0) begin
        qs_q <= nx - 1'b1; rs_q <= ny - 1'b1;
      end
    end
    if (cmd_i.em_init) begin
      k_q <= '0;
      n_q <= (int'(len_q) > MaxResults) ? LW'(MaxResults) : len_q;
    end
    if (cmd_i.em_pop) k_q <= k_q + 1'b1;
    if (cmd_i.em_ld || cmd_i.em_solo) begin
      best_score_o  <= best_q;
      none_found_o  <= cmd_i.em_solo && (best_q == 10'd0);
      query_start_o <= (best_q == 10'd0) ? 5'd0 : 5'(qs_q);
      ref_start_o   <= (best_q == 10'd0) ? 5'd0 : 5'(rs_q);
      query_end_o   <= (best_q == 10'd0) ? 5'd0 : 5'(bi_q - 1'b1);
      ref_end_o     <= (best_q == 10'd0) ? 5'd0 : 5'(bj_q - 1'b1);
    end
    if (cmd_i.em_ld) begin
      {query_char_o, query_is_gap_o, ref_char_o, ref_is_gap_o} <= col_rd;
      last_column_o <= ((k_q + 1'b1) == n_q);
    end
    if (cmd_i.em_solo) begin
      {query_char_o, query_is_gap_o, ref_char_o, ref_is_gap_o} <= '0;
      last_column_o <= 1'b1;
    end
  end

endmodule

FILE: rtl/local_sequence_aligner.sv
// ----------------------------------------------------------------------------
// local_sequence_aligner
// Smith-Waterman local aligner with linear gap penalty and traceback.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o   cmd_i, symbol_i
// out      output     out_valid_o/out_ready_i alignment column fields
// cfg      input      psel/penable/pwrite     paddr, pwdata, prdata
//
// A symbol load is taken only in the idle state. A run reads the score
// RAM once per matrix cell, three times per traceback step (three reads
// of the same RAM), then reads, loads and holds each result until it is accepted.
// Reset is asynchronous and active low; no clearing pass is needed.
// No new request is taken until the last result of a run is accepted.
// ----------------------------------------------------------------------------
module local_sequence_aligner #(
  parameter int unsigned MAX_LEN = lsa_pkg::MaxLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  query_char_o,
  output logic        query_is_gap_o,
  output logic [7:0]  ref_char_o,
  output logic        ref_is_gap_o,
  output logic        last_column_o,
  output logic        none_found_o,
  output logic [4:0]  query_start_o,
  output logic [4:0]  query_end_o,
  output logic [4:0]  ref_start_o,
  output logic [4:0]  ref_end_o,
  output logic [9:0]  best_score_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsa_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  lsa_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  lsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  lsa_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i(cmd), .status_o(status), .symbol_i,
    .query_char_o, .query_is_gap_o, .ref_char_o, .ref_is_gap_o, .last_column_o,
    .none_found_o, .query_start_o, .query_end_o, .ref_start_o, .ref_end_o,
    .best_score_o
  );

endmodule
